// File: src/dqne_pkg.sv
// ----------------------------------------------------------------------------
// DNS query name extractor package
// Shared types, codes and constants for the name extractor block.
// ----------------------------------------------------------------------------
package dqne_pkg;

  // Kind of a result item.
  typedef enum logic [1:0] {
    KIND_CHAR   = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2
  } kind_e;

  // Reason carried by a reject verdict.
  typedef enum logic [3:0] {
    RSN_ETHERTYPE  = 4'd0,
    RSN_PROTOCOL   = 4'd1,
    RSN_PORT       = 4'd2,
    RSN_NO_QUEST   = 4'd3,
    RSN_TRUNCATED  = 4'd4,
    RSN_LABEL_LONG = 4'd5,
    RSN_NAME_LONG  = 4'd6,
    RSN_LABELS     = 4'd7,
    RSN_IHL        = 4'd8
  } reason_e;

  // Configuration port.
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] REG_DNS_PORT   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_MAX_LABELS = 2'd1;

  localparam logic [15:0] DNS_PORT_RST   = 16'd53;
  localparam logic [5:0]  MAX_LABELS_RST = 6'd32;

  // Stream widths.
  localparam int InDataW  = 8;
  localparam int OutDataW = 24;
  localparam int OutUserW = 2;

  // Results per input item and queue between front and back.
  localparam int MaxRes     = 3;
  localparam int QueueDepth = 4;

  // One result: the kind and one byte that is the character, the length
  // or the reason, depending on the kind.
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  val;
  } res_t;

  // All results caused by one input item, filled from index 0 up.
  typedef struct packed {
    logic [1:0]            count;
    res_t [MaxRes-1:0]     res;
  } bundle_t;

  function automatic res_t mk_res(kind_e k, logic [7:0] v);
    res_t r;
    r.kind = k;
    r.val  = v;
    return r;
  endfunction

endpackage

// File: src/dns_query_name_extractor_top.sv
// ----------------------------------------------------------------------------
// DNS query name extractor
// Checks each Ethernet frame for an IPv4/UDP DNS query and sends out the
// first question name as dotted text, followed by one verdict per frame.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                    Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   frame byte, tlast end
// m_axis    out        m_axis_tvalid/m_axis_tready   result, tuser kind
// cfg       in         cfg_valid_i/cfg_ready_o       register index, data
//
// One frame byte is taken per cycle while the four-entry bundle queue has
// room; a byte can cause up to three results, which leave one per cycle while
// m_axis_tready is high, each via the bundle queue and the output register.
// Reset sets dns_port to 53, max_labels to 32 and clears the frame state.
// Output stalls fill the queue and then hold s_axis_tready low.
// ----------------------------------------------------------------------------
module dns_query_name_extractor_top #(
  parameter int NameMax = 253
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dqne_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dqne_pkg::CfgDataW-1:0] cfg_data_i,
  // Frame input.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [dqne_pkg::InDataW-1:0]  s_axis_tdata,  // [7:0] pkt_byte
  input  logic                          s_axis_tlast,
  // Result output.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] name_char, [15:8] name_length, [19:16] reject_reason, [23:20] zero
  output logic [dqne_pkg::OutDataW-1:0] m_axis_tdata,
  output logic [dqne_pkg::OutUserW-1:0] m_axis_tuser,  // [1:0] out_kind
  output logic                          m_axis_tlast
);

  logic              push;
  logic              pop;
  logic              full;
  logic              empty;
  dqne_pkg::bundle_t bundle;
  dqne_pkg::bundle_t head;

  assign cfg_ready_o = 1'b1;

  dqne_front #(
    .NameMax (NameMax)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .push_o      (push),
    .bundle_o    (bundle),
    .full_i      (full)
  );

  dqne_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .bundle_i (bundle),
    .full_o   (full),
    .pop_i    (pop),
    .empty_o  (empty),
    .head_o   (head)
  );

  dqne_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .head_i        (head),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// File: src/dqne_front.sv
// ----------------------------------------------------------------------------
// DNS query name extractor front end
// Parses one frame byte per cycle while the queue has room, holds the config
// registers and hands the results of each byte to the queue as one bundle.
// ----------------------------------------------------------------------------
module dqne_front #(
  parameter int NameMax = 253
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration writes.
  input  logic                          cfg_valid_i,
  input  logic [dqne_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dqne_pkg::CfgDataW-1:0] cfg_data_i,
  // Frame bytes.
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    in_byte_i,
  input  logic                          in_last_i,
  // Bundles toward the queue.
  output logic                          push_o,
  output dqne_pkg::bundle_t             bundle_o,
  input  logic                          full_i
);

  typedef enum logic [1:0] {
    PH_HEAD  = 2'd0,
    PH_LEN   = 2'd1,
    PH_CHARS = 2'd2,
    PH_DONE  = 2'd3
  } phase_e;

  // Header byte positions of the fixed fields.
  localparam logic [6:0] POS_ETYPE_HI = 7'd12;
  localparam logic [6:0] POS_ETYPE_LO = 7'd13;
  localparam logic [6:0] POS_IHL      = 7'd14;
  localparam logic [6:0] POS_PROTO    = 7'd23;
  localparam logic [6:0] POS_IP_END   = 7'd33;
  localparam logic [6:0] ETH_LEN      = 7'd14;
  localparam logic [6:0] UDP_LEN      = 7'd8;

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] PROTO_UDP  = 16'd17;
  localparam logic [3:0]  IHL_MIN    = 4'd5;
  localparam logic [7:0]  LABEL_MAX  = 8'd63;
  localparam logic [7:0]  NameMaxW   = 8'(NameMax);
  localparam logic [7:0]  DOT_CHAR   = 8'h2e;

  logic [15:0] dns_port_q;
  logic [5:0]  max_labels_q;

  phase_e      phase_q, phase_d;
  logic [6:0]  pos_q, pos_d;
  logic [3:0]  ihl_q, ihl_d;
  logic [15:0] shift_q, shift_d;
  logic [5:0]  left_q, left_d;
  logic [5:0]  lcnt_q, lcnt_d;
  logic [7:0]  ncnt_q, ncnt_d;

  logic        accept;
  logic        stop;
  logic [1:0]  n;
  logic [6:0]  udp_base;
  logic [6:0]  dns_base;
  dqne_pkg::res_t [dqne_pkg::MaxRes-1:0] res;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;

  // Start offsets of the UDP and DNS headers behind the IPv4 options.
  assign udp_base = ETH_LEN + {1'b0, ihl_q, 2'b00};
  assign dns_base = udp_base + UDP_LEN;

  // Per-byte parse step and result assembly.
  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    ihl_d   = ihl_q;
    shift_d = shift_q;
    left_d  = left_q;
    lcnt_d  = lcnt_q;
    ncnt_d  = ncnt_q;
    stop    = 1'b0;
    n       = 2'd0;
    res     = '0;

    case (phase_q)
      PH_HEAD: begin
        if (pos_q == POS_ETYPE_HI) begin
          shift_d = {8'h00, in_byte_i};
        end
        if (pos_q == POS_ETYPE_LO) begin
          shift_d = {shift_q[7:0], in_byte_i};
          if ({shift_q[7:0], in_byte_i} != ETYPE_IPV4) begin
            res[n]  = dqne_pkg::mk_res(dqne_pkg::KIND_REJECT,
                                       {4'h0, dqne_pkg::RSN_ETHERTYPE});
            n       = n + 2'd1;
            phase_d = PH_DONE;
            stop    = 1'b1;
          end
        end
        if (!stop && pos_q == POS_IHL) begin
          ihl_d = in_byte_i[3:0];
        end
        if (!stop && pos_q == POS_PROTO) begin
          shift_d = {8'h00, in_byte_i};
        end
        if (!stop && pos_q == POS_IP_END) begin
          if (shift_q != PROTO_UDP) begin
            res[n]  = dqne_pkg::mk_res(dqne_pkg::KIND_REJECT,
                                       {4'h0, dqne_pkg::RSN_PROTOCOL});
            n       = n + 2'd1;
            phase_d = PH_DONE;
            stop    = 1'b1;
          end else if (ihl_q < IHL_MIN) begin
            res[n]  = dqne_pkg::mk_res(dqne_pkg::KIND_REJECT,
                                       {4'h0, dqne_pkg::RSN_IHL});
            n       = n + 2'd1;
            phase_d = PH_DONE;
            stop    = 1'b1;
          end
        end
        // UDP and DNS fields sit behind the variable IPv4 header.
        if (!stop && pos_q > POS_IP_END) begin
          if (pos_q == udp_base + 7'd2 || pos_q == dns_base + 7'd4) begin
            shift_d = {8'h00, in_byte_i};
          end
          if (pos_q == udp_base + 7'd3 || pos_q == dns_base + 7'd5) begin
            shift_d = {shift_q[7:0], in_byte_i};
          end
          if (pos_q == udp_base + 7'd7 && shift_q != dns_port_q) begin
            res[n]  = dqne_pkg::mk_res(dqne_pkg::KIND_REJECT,
                                       {4'h0, dqne_pkg::RSN_PORT});
            n       = n + 2'd1;
            phase_d = PH_DONE;
            stop    = 1'b1;
          end
          if (!stop && pos_q == dns_base + 7'd11) begin
            if (shift_q == 16'd0) begin
              res[n]  = dqne_pkg::mk_res(dqne_pkg::KIND_REJECT,
                                         {4'h0, dqne_pkg::RSN_NO_QUEST});
              n       = n + 2'd1;
              phase_d = PH_DONE;
              stop    = 1'b1;
            end else begin
              phase_d = PH_LEN;
            end
          end
        end
        if (!stop) begin
          pos_d = pos_q + 7'd1;
        end
      end
      PH_LEN: begin
        if (in_byte_i == 8'd0) begin
          res[n]  = dqne_pkg::mk_res(dqne_pkg::KIND_ACCEPT, ncnt_q);
          n       = n + 2'd1;
          phase_d = PH_DONE;
        end else if (in_byte_i > LABEL_MAX) begin
          res[n]  = dqne_pkg::mk_res(dqne_pkg::KIND_REJECT,
                                     {4'h0, dqne_pkg::RSN_LABEL_LONG});
          n       = n + 2'd1;
          phase_d = PH_DONE;
        end else begin
          left_d  = in_byte_i[5:0];
          phase_d = PH_CHARS;
        end
      end
      PH_CHARS: begin
        if (ncnt_q >= NameMaxW) begin
          res[n]  = dqne_pkg::mk_res(dqne_pkg::KIND_REJECT,
                                     {4'h0, dqne_pkg::RSN_NAME_LONG});
          n       = n + 2'd1;
          phase_d = PH_DONE;
        end else begin
          res[n] = dqne_pkg::mk_res(dqne_pkg::KIND_CHAR, in_byte_i);
          n      = n + 2'd1;
          ncnt_d = ncnt_q + 8'd1;
          left_d = left_q - 6'd1;
          // End of label: the name limit, then a dot and the label limit.
          if (left_d == 6'd0) begin
            if (ncnt_d >= NameMaxW) begin
              res[n]  = dqne_pkg::mk_res(dqne_pkg::KIND_REJECT,
                                         {4'h0, dqne_pkg::RSN_NAME_LONG});
              n       = n + 2'd1;
              phase_d = PH_DONE;
            end else begin
              res[n] = dqne_pkg::mk_res(dqne_pkg::KIND_CHAR, DOT_CHAR);
              n      = n + 2'd1;
              ncnt_d = ncnt_q + 8'd2;
              lcnt_d = lcnt_q + 6'd1;
              if (lcnt_d >= max_labels_q) begin
                res[n]  = dqne_pkg::mk_res(dqne_pkg::KIND_REJECT,
                                           {4'h0, dqne_pkg::RSN_LABELS});
                n       = n + 2'd1;
                phase_d = PH_DONE;
              end else begin
                phase_d = PH_LEN;
              end
            end
          end
        end
      end
      default: begin
        // Verdict already given: bytes are ignored.
      end
    endcase

    // A frame that ends without a verdict is truncated.
    if (in_last_i && phase_q != PH_DONE && phase_d != PH_DONE) begin
      res[n]  = dqne_pkg::mk_res(dqne_pkg::KIND_REJECT,
                                 {4'h0, dqne_pkg::RSN_TRUNCATED});
      n       = n + 2'd1;
      phase_d = PH_DONE;
    end

    // The last byte clears the frame state.
    if (in_last_i) begin
      phase_d = PH_HEAD;
      pos_d   = '0;
      ihl_d   = '0;
      shift_d = '0;
      left_d  = '0;
      lcnt_d  = '0;
      ncnt_d  = '0;
    end
  end

  assign push_o         = accept && (n != 2'd0);
  assign bundle_o.count = n;
  assign bundle_o.res   = res;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dns_port_q   <= dqne_pkg::DNS_PORT_RST;
      max_labels_q <= dqne_pkg::MAX_LABELS_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dqne_pkg::REG_DNS_PORT: begin
          dns_port_q <= cfg_data_i;
        end
        dqne_pkg::REG_MAX_LABELS: begin
          max_labels_q <= cfg_data_i[5:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Frame state, updated on each accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEAD;
      pos_q   <= '0;
      ihl_q   <= '0;
      shift_q <= '0;
      left_q  <= '0;
      lcnt_q  <= '0;
      ncnt_q  <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      ihl_q   <= ihl_d;
      shift_q <= shift_d;
      left_q  <= left_d;
      lcnt_q  <= lcnt_d;
      ncnt_q  <= ncnt_d;
    end
  end

endmodule

// File: src/dqne_queue.sv
// ----------------------------------------------------------------------------
// DNS query name extractor result queue
// A short register queue of result bundles between the front and back ends.
// ----------------------------------------------------------------------------
module dqne_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  dqne_pkg::bundle_t bundle_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output dqne_pkg::bundle_t head_o
);

  localparam int PtrW = $clog2(dqne_pkg::QueueDepth);
  localparam int CntW = $clog2(dqne_pkg::QueueDepth + 1);
  localparam logic [PtrW-1:0] PTR_LAST = PtrW'(dqne_pkg::QueueDepth - 1);
  localparam logic [CntW-1:0] CNT_FULL = CntW'(dqne_pkg::QueueDepth);

  dqne_pkg::bundle_t mem_q [dqne_pkg::QueueDepth];
  logic [PtrW-1:0]   wptr_q, rptr_q;
  logic [CntW-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_FULL);
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rptr_q];

  // Occupancy follows pushes and pops.
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  // Storage, no reset needed.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= bundle_i;
    end
  end

  // Pointers and count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PTR_LAST) ? '0 : wptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PTR_LAST) ? '0 : rptr_q + PtrW'(1);
      end
      cnt_q <= cnt_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_FULL)
    else $error("queue count beyond depth");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> cnt_q == $past(cnt_q) + CntW'(1))
    else $error("push did not grow the queue");
  a_bundle_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> bundle_i.count != 2'd0)
    else $error("empty bundle pushed");
`endif

endmodule

// File: src/dqne_back.sv
// ----------------------------------------------------------------------------
// DNS query name extractor back end
// Walks through the results of the head bundle and sends them out one per
// cycle through an output register while m_axis_tready is high.
// ----------------------------------------------------------------------------
module dqne_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  input  dqne_pkg::bundle_t             head_i,
  output logic                          pop_o,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [dqne_pkg::OutDataW-1:0] m_axis_tdata,
  output logic [dqne_pkg::OutUserW-1:0] m_axis_tuser,
  output logic                          m_axis_tlast
);

  logic           valid_q;
  logic [1:0]     idx_q;
  dqne_pkg::res_t out_q;
  dqne_pkg::res_t cur;
  logic           load;
  logic           at_end;

  // Next result of the head bundle.
  assign cur    = head_i.res[idx_q];
  assign load   = !empty_i && (!valid_q || m_axis_tready);
  assign at_end = (idx_q == head_i.count - 2'd1);
  assign pop_o  = load && at_end;

  // Output register and position inside the head bundle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= at_end ? 2'd0 : idx_q + 2'd1;
      end else if (m_axis_tready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= cur;
    end
  end

  // Fields shown only for the kind that carries them.
  assign m_axis_tvalid = valid_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = (out_q.kind != dqne_pkg::KIND_CHAR);
  assign m_axis_tdata  = {4'h0,
                          (out_q.kind == dqne_pkg::KIND_REJECT) ? out_q.val[3:0] : 4'h0,
                          (out_q.kind == dqne_pkg::KIND_ACCEPT) ? out_q.val : 8'h00,
                          (out_q.kind == dqne_pkg::KIND_CHAR) ? out_q.val : 8'h00};

`ifndef NO_ASSERTIONS
  a_idx_in_bundle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> idx_q < head_i.count)
    else $error("result index beyond bundle");
  a_idx_reset_on_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> idx_q == 2'd0)
    else $error("index not cleared after pop");
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> m_axis_tvalid)
    else $error("loaded result not shown");
`endif

endmodule
